[rtl/vlnd_pkg.sv]
// Package for the varint length newline deframer.
// Holds the phase and status codes and the fixed field widths and constants.
// No dependencies.
`default_nettype none

package vlnd_pkg;

  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 16;
  localparam int MSG_LEN_W = 16;

  localparam logic [CFG_W-1:0]  MAX_LEN_RESET = 16'd1024;
  localparam logic [BYTE_W-1:0] NEWLINE_CHAR  = 8'h0A;
  localparam logic [BYTE_W-1:0] DATA_BITS     = 8'h7F;
  localparam logic [BYTE_W-1:0] CONT_BIT      = 8'h80;

  // One-hot deframer phase
  typedef enum logic [2:0] {
    PH_PREFIX  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_HALTED  = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_ZERO        = 3'd1,
    ST_TOO_LONG    = 3'd2,
    ST_NO_NEWLINE  = 3'd3,
    ST_PREFIX_LONG = 3'd4
  } status_t;

endpackage

`default_nettype wire

[rtl/vlnd_if.sv]
// Valid/ready channel interfaces of the deframer: raw byte in, result record out.
// Depends on vlnd_pkg for field widths and the status type.
`default_nettype none

interface vlnd_in_if;
  logic                         valid;
  logic                         ready;
  logic [vlnd_pkg::BYTE_W-1:0]  in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface vlnd_out_if;
  logic                           valid;
  logic                           ready;
  logic [vlnd_pkg::BYTE_W-1:0]    out_byte;
  logic                           is_payload;
  logic                           first_of_message;
  logic                           frame_end;
  vlnd_pkg::status_t              frame_status;
  logic [vlnd_pkg::MSG_LEN_W-1:0] message_length;

  modport source (output valid, output out_byte, output is_payload, output first_of_message,
                  output frame_end, output frame_status, output message_length,
                  input ready);
  modport sink   (input valid, input out_byte, input is_payload, input first_of_message,
                  input frame_end, input frame_status, input message_length,
                  output ready);
endinterface

`default_nettype wire

[rtl/varint_length_newline_deframer.sv]
// Deframer for unsigned-LEB128 length-prefixed, newline-terminated messages.
// Depends on vlnd_pkg and the channel interfaces in vlnd_if.sv.
//
// Usage:
//   in_ch  carries one raw stream byte per item (valid/ready).
//   out_ch carries at most one result record per input byte: a payload byte
//          (first one of a message marked) or a frame-end record with status
//          and message length. Prefix bytes produce a record only on an error.
//   cfg_we/cfg_wdata write max_payload_len (newline included); write it only
//   while the block is idle. Reset value is 1024.
// Output: the record caused by a byte is registered and is valid on out_ch in the
//   cycle after the byte is accepted.
// Throughput: one byte per cycle unless out_ch stalls. Each byte is decoded by a
//   single pass of logic from the phase/length registers into the output register.
// Stall: a byte is accepted while the output register is empty or being
//   drained in the same cycle; when out_ch stalls with a record waiting,
//   in_ch.ready drops until it is taken.
// Reset: rst_n (synchronous, active low) returns to reading a length prefix
//   and empties the output register. Any error record halts the block: bytes
//   are still accepted but dropped until the next reset. Payload bytes leave
//   before the newline is checked, so drop a frame whose end status is an error.
`default_nettype none

module varint_length_newline_deframer #(
  parameter int LENGTH_WIDTH     = 16,
  parameter int MAX_PREFIX_BYTES = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  vlnd_in_if.sink                         in_ch,
  vlnd_out_if.source                      out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [vlnd_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int LW     = LENGTH_WIDTH;
  localparam int CNT_W  = $clog2(MAX_PREFIX_BYTES + 1);
  localparam int SHF_W  = $clog2(7 * MAX_PREFIX_BYTES);
  localparam int GRP_W  = 7 * MAX_PREFIX_BYTES;
  localparam int PART_W = (GRP_W > LW) ? GRP_W : LW + 1;
  localparam int CMP_W  = (LW > vlnd_pkg::CFG_W) ? LW : vlnd_pkg::CFG_W;

  vlnd_pkg::phase_t            phase_r, phase_nxt;
  logic [LW-1:0]               accum_r, accum_nxt;
  logic                        too_big_r, too_big_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [LW-1:0]               left_r, left_nxt;
  logic                        first_r, first_nxt;
  logic [vlnd_pkg::CFG_W-1:0]  max_len_r;

  logic                        out_valid_r;
  logic [vlnd_pkg::BYTE_W-1:0] out_byte_r, res_byte;
  logic                        out_pay_r, res_pay;
  logic                        out_first_r, res_first;
  logic                        out_end_r, res_end;
  vlnd_pkg::status_t           out_status_r, res_status;
  logic [vlnd_pkg::MSG_LEN_W-1:0] out_len_r, res_len;
  logic                        res_valid;

  logic                        in_acc;
  logic [vlnd_pkg::BYTE_W-1:0] in_b;
  logic [SHF_W-1:0]            shamt;
  logic [PART_W-1:0]           part;
  logic [LW-1:0]               acc_upd;
  logic                        big_upd;
  logic [CNT_W-1:0]            cnt_inc;
  logic [LW-1:0]               accum_m1;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_b        = in_ch.in_byte;

  // Place the 7 data bits of this prefix byte at their group position
  assign shamt    = SHF_W'(cnt_r) * SHF_W'(3'd7);
  assign part     = PART_W'(in_b & vlnd_pkg::DATA_BITS) << shamt;
  assign acc_upd  = accum_r | part[LW-1:0];
  assign big_upd  = too_big_r || (|part[PART_W-1:LW]);
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign accum_m1 = accum_r - LW'(1);

  always_comb begin
    phase_nxt   = phase_r;
    accum_nxt   = accum_r;
    too_big_nxt = too_big_r;
    cnt_nxt     = cnt_r;
    left_nxt    = left_r;
    first_nxt   = first_r;
    res_valid   = 1'b0;
    res_byte    = '0;
    res_pay     = 1'b0;
    res_first   = 1'b0;
    res_end     = 1'b0;
    res_status  = vlnd_pkg::ST_OK;
    res_len     = '0;
    if (in_acc) begin
      unique case (phase_r)
        vlnd_pkg::PH_PREFIX: begin
          accum_nxt   = acc_upd;
          too_big_nxt = big_upd;
          if ((in_b & vlnd_pkg::CONT_BIT) != '0) begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= CNT_W'(MAX_PREFIX_BYTES)) begin
              phase_nxt  = vlnd_pkg::PH_HALTED;
              res_valid  = 1'b1;
              res_end    = 1'b1;
              res_status = vlnd_pkg::ST_PREFIX_LONG;
            end
          end else if (big_upd || (CMP_W'(acc_upd) > CMP_W'(max_len_r))) begin
            phase_nxt  = vlnd_pkg::PH_HALTED;
            res_valid  = 1'b1;
            res_end    = 1'b1;
            res_status = vlnd_pkg::ST_TOO_LONG;
          end else if (acc_upd == '0) begin
            phase_nxt  = vlnd_pkg::PH_HALTED;
            res_valid  = 1'b1;
            res_end    = 1'b1;
            res_status = vlnd_pkg::ST_ZERO;
          end else begin
            left_nxt  = acc_upd;
            first_nxt = 1'b1;
            phase_nxt = vlnd_pkg::PH_PAYLOAD;
          end
        end
        vlnd_pkg::PH_PAYLOAD: begin
          if (left_r > LW'(1)) begin
            res_valid = 1'b1;
            res_byte  = in_b;
            res_pay   = 1'b1;
            res_first = first_r;
            first_nxt = 1'b0;
            left_nxt  = left_r - LW'(1);
          end else if (in_b != vlnd_pkg::NEWLINE_CHAR) begin
            phase_nxt  = vlnd_pkg::PH_HALTED;
            res_valid  = 1'b1;
            res_end    = 1'b1;
            res_status = vlnd_pkg::ST_NO_NEWLINE;
          end else begin
            res_valid   = 1'b1;
            res_end     = 1'b1;
            res_len     = vlnd_pkg::MSG_LEN_W'(accum_m1);
            // start over on the next prefix
            phase_nxt   = vlnd_pkg::PH_PREFIX;
            accum_nxt   = '0;
            too_big_nxt = 1'b0;
            cnt_nxt     = '0;
            left_nxt    = '0;
            first_nxt   = 1'b1;
          end
        end
        vlnd_pkg::PH_HALTED: begin
          // drop the byte
        end
        default: begin
          phase_nxt = vlnd_pkg::PH_HALTED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= vlnd_pkg::PH_PREFIX;
      accum_r     <= '0;
      too_big_r   <= 1'b0;
      cnt_r       <= '0;
      left_r      <= '0;
      first_r     <= 1'b1;
      max_len_r   <= vlnd_pkg::MAX_LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      accum_r   <= accum_nxt;
      too_big_r <= too_big_nxt;
      cnt_r     <= cnt_nxt;
      left_r    <= left_nxt;
      first_r   <= first_nxt;
      if (cfg_we) begin
        max_len_r <= cfg_wdata;
      end
      if (in_acc) begin
        out_valid_r <= res_valid;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_byte_r   <= res_byte;
      out_pay_r    <= res_pay;
      out_first_r  <= res_first;
      out_end_r    <= res_end;
      out_status_r <= res_status;
      out_len_r    <= res_len;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.out_byte         = out_byte_r;
  assign out_ch.is_payload       = out_pay_r;
  assign out_ch.first_of_message = out_first_r;
  assign out_ch.frame_end        = out_end_r;
  assign out_ch.frame_status     = out_status_r;
  assign out_ch.message_length   = out_len_r;

`ifndef SYNTH
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == vlnd_pkg::PH_HALTED |=> phase_r == vlnd_pkg::PH_HALTED)
    else $error("deframer left the halted phase without reset");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc && (!out_valid_r || out_ch.ready) |=> !out_valid_r)
    else $error("result appeared without an accepted byte");

  a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == vlnd_pkg::PH_HALTED && !out_valid_r |=> !out_valid_r)
    else $error("result emitted while halted");

  a_prefix_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == vlnd_pkg::PH_PREFIX |-> cnt_r < CNT_W'(MAX_PREFIX_BYTES))
    else $error("prefix byte count out of range");
`endif

endmodule

`default_nettype wire
